FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit.
// Holds the operation and status codes, the divider pipeline word type and helpers.
// No dependencies.
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QUO_BITS  = 32;   // quotient bits produced by the divider pipe

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_DZ  = 2'd1,
      ST_SAT = 2'd2,
      ST_RSV = 2'd3
   } status_type;

   // word moving through the divider steps; finished results ride along
   typedef struct packed {
      logic        vld;
      logic        is_div;
      logic        dz;
      logic        neg_re;
      logic        neg_im;
      logic        ovf_re;
      logic        ovf_im;
      logic [64:0] rem_re;
      logic [64:0] rem_im;
      logic [31:0] nl_re;
      logic [31:0] nl_im;
      logic [31:0] q_re;
      logic [31:0] q_im;
      logic [63:0] den;
      logic [31:0] res_re;
      logic [31:0] res_im;
      status_type  status;
   } div_word_type;

   // clamp a 65-bit signed value to 32 bits; bit 32 of the result flags a clamp
   function automatic logic [32:0] sat65(input logic signed [64:0] v);
      logic fits;
      fits = (&v[64:31]) | ~(|v[64:31]);
      if (fits)
         sat65 = {1'b0, v[31:0]};
      else if (v[64])
         sat65 = {1'b1, 32'h8000_0000};
      else
         sat65 = {1'b1, 32'h7FFF_FFFF};
   endfunction

   // sign a 32-bit quotient magnitude and clamp; bit 32 flags a clamp
   function automatic logic [32:0] sat_quo(input logic neg, input logic ovf,
                                           input logic [31:0] q);
      if (neg) begin
         if (ovf || q > 32'h8000_0000)
            sat_quo = {1'b1, 32'h8000_0000};
         else
            sat_quo = {1'b0, 32'(-q)};
      end else begin
         if (ovf || q[31])
            sat_quo = {1'b1, 32'h7FFF_FFFF};
         else
            sat_quo = {1'b0, q};
      end
   endfunction

endpackage

FILE: design/cau_front.sv
// Front of the pipeline: products, sums, abs and overflow check, non-divide results.
// Three register stages; depends on cau_pkg.
module cau_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [1:0]           in_op,
   input  logic signed [31:0]   in_a_re,
   input  logic signed [31:0]   in_a_im,
   input  logic signed [31:0]   in_b_re,
   input  logic signed [31:0]   in_b_im,
   output cau_pkg::div_word_type out_ff
);
   import cau_pkg::*;

   // stage 1: products and add/sub
   logic               s1_vld_ff;
   logic [1:0]         s1_op_ff;
   logic signed [63:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_bb0_ff, s1_bb1_ff;
   logic signed [32:0] s1_sre_ff, s1_sim_ff;
   logic signed [32:0] s1_sre_in, s1_sim_in;

   always_comb begin
      if (in_op == OP_SUB) begin
         s1_sre_in = 33'(in_a_re) - 33'(in_b_re);
         s1_sim_in = 33'(in_a_im) - 33'(in_b_im);
      end else begin
         s1_sre_in = 33'(in_a_re) + 33'(in_b_re);
         s1_sim_in = 33'(in_a_im) + 33'(in_b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
      end
      if (en) begin
         s1_op_ff  <= in_op;
         s1_rr_ff  <= in_a_re * in_b_re;
         s1_ii_ff  <= in_a_im * in_b_im;
         s1_ri_ff  <= in_a_re * in_b_im;
         s1_ir_ff  <= in_a_im * in_b_re;
         s1_bb0_ff <= in_b_re * in_b_re;
         s1_bb1_ff <= in_b_im * in_b_im;
         s1_sre_ff <= s1_sre_in;
         s1_sim_ff <= s1_sim_in;
      end
   end

   // stage 2: combine products per operation
   logic               s2_vld_ff, s2_div_ff;
   logic signed [64:0] s2_re_ff, s2_im_ff, s2_re_in, s2_im_in;
   logic [63:0]        s2_den_ff;

   always_comb begin
      case (s1_op_ff)
         OP_ADD, OP_SUB: begin
            s2_re_in = 65'(s1_sre_ff);
            s2_im_in = 65'(s1_sim_ff);
         end
         OP_MUL: begin
            s2_re_in = 65'(s1_rr_ff) - 65'(s1_ii_ff);
            s2_im_in = 65'(s1_ri_ff) + 65'(s1_ir_ff);
         end
         default: begin
            s2_re_in = 65'(s1_rr_ff) + 65'(s1_ii_ff);
            s2_im_in = 65'(s1_ir_ff) - 65'(s1_ri_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_div_ff <= (s1_op_ff == OP_DIV);
         s2_re_ff  <= (s1_op_ff == OP_MUL) ? (s2_re_in >>> FRAC_BITS) : s2_re_in;
         s2_im_ff  <= (s1_op_ff == OP_MUL) ? (s2_im_in >>> FRAC_BITS) : s2_im_in;
         s2_den_ff <= 64'(s1_bb0_ff) + 64'(s1_bb1_ff);
      end
   end

   // stage 3: magnitudes, quotient overflow, divider seed; other ops finish here
   logic [64:0]  mag_re, mag_im;
   logic [95:0]  den_lim;
   logic [32:0]  sat_re, sat_im;
   div_word_type out_in;

   always_comb begin
      mag_re  = s2_re_ff[64] ? 65'(-s2_re_ff) : 65'(s2_re_ff);
      mag_im  = s2_im_ff[64] ? 65'(-s2_im_ff) : 65'(s2_im_ff);
      den_lim = 96'(s2_den_ff) << (QUO_BITS - FRAC_BITS);
      sat_re  = sat65(s2_re_ff);
      sat_im  = sat65(s2_im_ff);
      out_in.vld    = s2_vld_ff;
      out_in.is_div = s2_div_ff;
      out_in.dz     = (s2_den_ff == '0);
      out_in.neg_re = s2_re_ff[64];
      out_in.neg_im = s2_im_ff[64];
      out_in.ovf_re = 96'(mag_re[63:0]) >= den_lim;
      out_in.ovf_im = 96'(mag_im[63:0]) >= den_lim;
      // remainder starts as the numerator bits above the quotient field
      out_in.rem_re = 65'(mag_re[63:0] >> (QUO_BITS - FRAC_BITS));
      out_in.rem_im = 65'(mag_im[63:0] >> (QUO_BITS - FRAC_BITS));
      out_in.nl_re  = 32'(mag_re[63:0] << FRAC_BITS);
      out_in.nl_im  = 32'(mag_im[63:0] << FRAC_BITS);
      out_in.q_re   = '0;
      out_in.q_im   = '0;
      out_in.den    = s2_den_ff;
      out_in.res_re = sat_re[31:0];
      out_in.res_im = sat_im[31:0];
      out_in.status = (sat_re[32] || sat_im[32]) ? ST_SAT : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (en) begin
         out_ff.vld <= out_in.vld;
      end
      if (en) begin
         out_ff[$bits(div_word_type)-2:0] <= out_in[$bits(div_word_type)-2:0];
      end
   end

endmodule

FILE: design/cau_div_step.sv
// One restoring-division step: one quotient bit for each of the real and imaginary parts.
// Depends on cau_pkg.
module cau_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cau_pkg::div_word_type d_in,
   output cau_pkg::div_word_type d_ff
);
   import cau_pkg::*;

   logic [64:0]  sh_re, sh_im;
   logic         ge_re, ge_im;
   div_word_type d_in_nxt;

   always_comb begin
      sh_re = {d_in.rem_re[63:0], d_in.nl_re[31]};
      sh_im = {d_in.rem_im[63:0], d_in.nl_im[31]};
      ge_re = sh_re >= {1'b0, d_in.den};
      ge_im = sh_im >= {1'b0, d_in.den};
      d_in_nxt        = d_in;
      d_in_nxt.rem_re = ge_re ? sh_re - {1'b0, d_in.den} : sh_re;
      d_in_nxt.rem_im = ge_im ? sh_im - {1'b0, d_in.den} : sh_im;
      d_in_nxt.nl_re  = {d_in.nl_re[30:0], 1'b0};
      d_in_nxt.nl_im  = {d_in.nl_im[30:0], 1'b0};
      d_in_nxt.q_re   = {d_in.q_re[30:0], ge_re};
      d_in_nxt.q_im   = {d_in.q_im[30:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.vld <= 1'b0;
      end else if (en) begin
         d_ff.vld <= d_in_nxt.vld;
      end
      if (en) begin
         d_ff[$bits(div_word_type)-2:0] <= d_in_nxt[$bits(div_word_type)-2:0];
      end
   end

endmodule

FILE: design/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front stages, divider pipe, output register.
// Depends on cau_pkg, cau_front and cau_div_step.
//
//  channel | direction | tdata                                 | tuser
//  req     | in        | a_re, a_im, b_re, b_im (128 bits)     | operation
//  rsp     | out       | res_re, res_im (64 bits)              | status
//
// Every operation takes the same path through the pipe (3 front stages, 32 divider steps,
// finish stage that is also the output register); the 32 one-bit division steps set the depth.
// One word is accepted every cycle while the output is not stalled. Reset is synchronous and clears valid bits only.
// A stalled output freezes the whole pipe; req_tready drops while it lasts.
module complex_arithmetic_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,  // a_re, a_im, b_re, b_im
   input  logic [1:0]    req_tuser,  // operation
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,  // res_re, res_im
   output logic [1:0]    rsp_tuser   // status
);
   import cau_pkg::*;

   logic         en;
   div_word_type pipe [QUO_BITS+1];

   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   cau_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_op   (req_tuser),
      .in_a_re (req_tdata[31:0]),
      .in_a_im (req_tdata[63:32]),
      .in_b_re (req_tdata[95:64]),
      .in_b_im (req_tdata[127:96]),
      .out_ff  (pipe[0])
   );

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_div
      cau_div_step u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (pipe[g]),
         .d_ff  (pipe[g+1])
      );
   end

   // finish: pass non-divide results, sign and clamp quotients, pick divide-by-zero
   div_word_type last;
   logic [32:0]  qre, qim;
   logic         fin_vld_ff;
   logic [31:0]  fin_re_ff, fin_im_ff, fin_re_in, fin_im_in;
   status_type   fin_st_ff, fin_st_in;

   always_comb begin
      last = pipe[QUO_BITS];
      qre  = sat_quo(last.neg_re, last.ovf_re, last.q_re);
      qim  = sat_quo(last.neg_im, last.ovf_im, last.q_im);
      if (!last.is_div) begin
         fin_re_in = last.res_re;
         fin_im_in = last.res_im;
         fin_st_in = last.status;
      end else if (last.dz) begin
         fin_re_in = '0;
         fin_im_in = '0;
         fin_st_in = ST_DZ;
      end else begin
         fin_re_in = qre[31:0];
         fin_im_in = qim[31:0];
         fin_st_in = (qre[32] || qim[32]) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         fin_vld_ff <= last.vld;
      end
      if (en) begin
         fin_re_ff <= fin_re_in;
         fin_im_ff <= fin_im_in;
         fin_st_ff <= fin_st_in;
      end
   end

   assign rsp_tvalid = fin_vld_ff;
   assign rsp_tdata  = {fin_im_ff, fin_re_ff};
   assign rsp_tuser  = fin_st_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_DZ) |-> rsp_tdata == '0)
      else $error("divide-by-zero word carries nonzero data");

   a_no_rsv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != ST_RSV)
      else $error("reserved status code on output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

endmodule
